@@ rtl/mci_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mci_pkg: shared types and constants of the 4x4 cofactor inverse
// Queue entry type, back-end state type, datapath widths and the helper
// functions that pick minor rows, minor columns and permutation terms.
// ----------------------------------------------------------------------------
package mci_pkg;

  localparam int ELEM_W              = 32;
  localparam int IDX_W               = 4;
  localparam int THR_W               = 31;
  localparam int THR_RESET           = 33;
  localparam int FRAC_DEFAULT        = 16;
  localparam int FRAC_MAX            = 24;
  localparam int QUEUE_DEPTH_DEFAULT = 4;
  localparam int COF_W               = 100;
  localparam int ACC_W               = 136;
  localparam int DEN_W               = 132;
  localparam int MUL_A_W             = 37;
  localparam int MUL_P_W             = MUL_A_W + ELEM_W;
  localparam int NUM_W               = COF_W + 2 * FRAC_MAX;
  localparam int CMP_W               = DEN_W + ELEM_W;

  localparam logic [2:0] TERM_LAST  = 3'd5;
  localparam logic [2:0] COF_MS_END = 3'd5;
  localparam logic [2:0] DET_MS_END = 3'd4;

  typedef struct packed {
    logic [ELEM_W-1:0] value;
    logic              last;
  } elem_item_t;

  typedef enum logic [3:0] {
    ST_COLLECT,
    ST_COF,
    ST_DET,
    ST_ABS,
    ST_TEST,
    ST_SING,
    ST_DIV_ADDR,
    ST_DIV_LOAD,
    ST_DIV_OVF,
    ST_DIV_RUN,
    ST_EMIT
  } state_t;

  // Position d (0..2) of a 3x3 minor mapped back to the 4x4 row or column.
  function automatic logic [1:0] minor_pos(input logic [1:0] skip, input logic [1:0] d);
    logic [1:0] pos;
    pos = (d >= skip) ? d + 2'd1 : d;
    return pos;
  endfunction

  // Column chosen by row d in permutation term t of a 3x3 determinant.
  function automatic logic [1:0] perm_col(input logic [2:0] t, input logic [1:0] d);
    logic [5:0] p;
    unique case (t)
      3'd0:    p = {2'd2, 2'd1, 2'd0};
      3'd1:    p = {2'd1, 2'd2, 2'd0};
      3'd2:    p = {2'd2, 2'd0, 2'd1};
      3'd3:    p = {2'd0, 2'd2, 2'd1};
      3'd4:    p = {2'd1, 2'd0, 2'd2};
      3'd5:    p = {2'd0, 2'd1, 2'd2};
      default: p = {2'd2, 2'd1, 2'd0};
    endcase
    return p[{d, 1'b0} +: 2];
  endfunction

  function automatic logic perm_odd(input logic [2:0] t);
    return (t == 3'd1) || (t == 3'd2) || (t == 3'd5);
  endfunction

endpackage

@@ rtl/matrix4_cofactor_inverse.sv @@
`timescale 1ns / 1ps
// After the sixteenth element is accepted the engine forms the 96 three-element
// cofactor products, then the determinant, then control and the first division
// (skipped for a singular result); each further inverse element has its own division,
// skipped when the quotient overflows. Output stalls add delay. A new matrix is collected
// only after the last result; elements enter one per cycle while the engine collects
// and the queue is not full. Reset (synchronous, active low) sets the threshold to 33.
// ----------------------------------------------------------------------------
// matrix4_cofactor_inverse: 4x4 fixed-point matrix inverse by cofactors
// Input side, element queue and arithmetic engine of the inverse.
// ----------------------------------------------------------------------------
module matrix4_cofactor_inverse
  import mci_pkg::*;
#(
  parameter int FRAC_BITS   = FRAC_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ELEM_W-1:0] in_element_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ELEM_W-1:0] out_inverse_value,
  output logic [IDX_W-1:0]  out_element_index,
  output logic              out_singular,
  output logic              out_last_of_run,
  input  logic              cfg_write_en,
  input  logic [THR_W-1:0]  cfg_write_data
);

  logic       q_full;
  logic       q_push;
  elem_item_t q_push_data;
  logic       q_pop;
  elem_item_t q_pop_data;
  logic       q_empty;

  mci_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_element_value (in_element_value),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_push_data      (q_push_data)
  );

  mci_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  mci_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_data            (q_pop_data),
    .q_pop             (q_pop),
    .cfg_write_en      (cfg_write_en),
    .cfg_write_data    (cfg_write_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_inverse_value (out_inverse_value),
    .out_element_index (out_element_index),
    .out_singular      (out_singular),
    .out_last_of_run   (out_last_of_run)
  );

endmodule

@@ rtl/mci_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mci_front: input acceptance
// Accepts matrix elements, counts their position and marks the last
// element of each matrix before handing it to the queue.
// ----------------------------------------------------------------------------
module mci_front
  import mci_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ELEM_W-1:0] in_element_value,
  input  logic              q_full,
  output logic              q_push,
  output elem_item_t        q_push_data
);

  logic [IDX_W-1:0] count_r;

  assign in_stall          = q_full;
  assign q_push            = in_valid && !q_full;
  assign q_push_data.value = in_element_value;
  assign q_push_data.last  = (count_r == {IDX_W{1'b1}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (q_push) begin
      count_r <= count_r + 1'b1;
    end
  end

endmodule

@@ rtl/mci_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mci_queue: element queue
// Short first-in first-out buffer between the input side and the
// arithmetic side.
// ----------------------------------------------------------------------------
module mci_queue
  import mci_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  elem_item_t push_data,
  output logic       full,
  input  logic       pop,
  output elem_item_t pop_data,
  output logic       empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  elem_item_t       entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/mci_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mci_back: cofactor, determinant and division engine
// Stores a matrix, forms all sixteen cofactors and the determinant with one
// shared multiplier, then divides each cofactor by a nonsingular determinant
// with a bit-serial restoring divider and drives the result register.
// ----------------------------------------------------------------------------
module mci_back
  import mci_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  elem_item_t        q_data,
  output logic              q_pop,
  input  logic              cfg_write_en,
  input  logic [THR_W-1:0]  cfg_write_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ELEM_W-1:0] out_inverse_value,
  output logic [IDX_W-1:0]  out_element_index,
  output logic              out_singular,
  output logic              out_last_of_run
);

  state_t state_r;
  state_t state_nxt;

  logic [THR_W-1:0]  thr_r;
  logic [IDX_W-1:0]  wr_r;
  logic [IDX_W-1:0]  k_r;
  logic [2:0]        ms_r;
  logic [2:0]        t_r;
  logic [4:0]        bit_r;

  logic [ELEM_W-1:0] mem [16];
  logic [COF_W-1:0]  cof_mem [16];

  logic signed [ELEM_W-1:0]  rd_r;
  logic signed [COF_W-1:0]   cof_rd_r;
  logic signed [ELEM_W-1:0]  x_r;
  logic signed [ELEM_W-1:0]  phi_r;
  logic signed [MUL_P_W-1:0] q_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic                      det_neg_r;
  logic [DEN_W-1:0]          den_r;
  logic [NUM_W-1:0]          num_r;
  logic [ELEM_W-1:0]         lo_r;
  logic [DEN_W-1:0]          rem_r;
  logic [ELEM_W-1:0]         quot_r;
  logic                      neg_r;
  logic                      ovf_r;

  logic              out_valid_r;
  logic [ELEM_W-1:0] out_value_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic              out_sing_r;
  logic              out_last_r;

  logic                      mem_we;
  logic [IDX_W-1:0]          rd_addr;
  logic [IDX_W-1:0]          cof_addr;
  logic                      mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic                      acc_add;
  logic [1:0]                acc_sh;
  logic                      cof_we;
  logic                      out_load;
  logic                      out_space;

  logic [1:0]              row_skip;
  logic [1:0]              col_skip;
  logic [IDX_W-1:0]        f0;
  logic [IDX_W-1:0]        f1;
  logic [IDX_W-1:0]        f2;
  logic                    term_neg;
  logic signed [ACC_W-1:0] addend;
  logic signed [ACC_W-1:0] acc_sum;
  logic [DEN_W-1:0]        thr_sh;
  logic                    singular;
  logic [COF_W-1:0]        cof_mag;
  logic                    ovf_cmp;
  logic [DEN_W:0]          trial;
  logic                    ge;
  logic [ELEM_W-1:0]       mag;
  logic [ELEM_W-1:0]       limit;
  logic [ELEM_W-1:0]       sat;

  assign out_space = !out_valid_r || !out_stall;

  assign row_skip = k_r[1:0];
  assign col_skip = k_r[3:2];
  assign f0 = {minor_pos(row_skip, 2'd0), minor_pos(col_skip, perm_col(t_r, 2'd0))};
  assign f1 = {minor_pos(row_skip, 2'd1), minor_pos(col_skip, perm_col(t_r, 2'd1))};
  assign f2 = {minor_pos(row_skip, 2'd2), minor_pos(col_skip, perm_col(t_r, 2'd2))};
  assign term_neg = (state_r == ST_COF) && (perm_odd(t_r) ^ row_skip[0] ^ col_skip[0]);

  assign addend  = ACC_W'(q_r) <<< {acc_sh, 5'b0};
  assign acc_sum = term_neg ? acc_r - addend : acc_r + addend;

  assign thr_sh   = DEN_W'(thr_r) << (3 * FRAC_BITS);
  assign singular = (den_r == '0) || (den_r < thr_sh);
  assign cof_mag  = cof_rd_r[COF_W-1] ? COF_W'(-cof_rd_r) : COF_W'(cof_rd_r);
  assign ovf_cmp  = (CMP_W'(num_r) >= (CMP_W'(den_r) << ELEM_W));

  assign trial = {rem_r, lo_r[bit_r]};
  assign ge    = (trial >= {1'b0, den_r});

  assign mag   = ovf_r ? {ELEM_W{1'b1}} : quot_r;
  assign limit = neg_r ? {1'b1, {(ELEM_W-1){1'b0}}} : {1'b0, {(ELEM_W-1){1'b1}}};
  assign sat   = (mag > limit) ? limit : mag;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_COLLECT: begin
        if (!q_empty && q_data.last) begin
          state_nxt = ST_COF;
        end
      end
      ST_COF: begin
        if (ms_r == COF_MS_END && t_r == TERM_LAST && k_r == {IDX_W{1'b1}}) begin
          state_nxt = ST_DET;
        end
      end
      ST_DET: begin
        if (ms_r == DET_MS_END && k_r[1:0] == 2'd3) begin
          state_nxt = ST_ABS;
        end
      end
      ST_ABS:      state_nxt = ST_TEST;
      ST_TEST:     state_nxt = singular ? ST_SING : ST_DIV_ADDR;
      ST_SING: begin
        if (out_space) begin
          state_nxt = ST_COLLECT;
        end
      end
      ST_DIV_ADDR: state_nxt = ST_DIV_LOAD;
      ST_DIV_LOAD: state_nxt = ST_DIV_OVF;
      ST_DIV_OVF:  state_nxt = ovf_cmp ? ST_EMIT : ST_DIV_RUN;
      ST_DIV_RUN: begin
        if (bit_r == '0) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_space) begin
          state_nxt = (k_r == {IDX_W{1'b1}}) ? ST_COLLECT : ST_DIV_ADDR;
        end
      end
      default:     state_nxt = ST_COLLECT;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    mem_we   = 1'b0;
    rd_addr  = f2;
    cof_addr = k_r;
    mul_en   = 1'b0;
    mul_a    = '0;
    acc_add  = 1'b0;
    acc_sh   = 2'd0;
    cof_we   = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      ST_COLLECT: begin
        q_pop  = !q_empty;
        mem_we = !q_empty;
      end
      ST_COF: begin
        case (ms_r)
          3'd0:    rd_addr = f0;
          3'd1:    rd_addr = f1;
          default: rd_addr = f2;
        endcase
        case (ms_r)
          3'd2: begin
            mul_en = 1'b1;
            mul_a  = MUL_A_W'(x_r);
          end
          3'd3: begin
            mul_en = 1'b1;
            mul_a  = $signed({{(MUL_A_W-ELEM_W){1'b0}}, q_r[ELEM_W-1:0]});
          end
          3'd4: begin
            mul_en  = 1'b1;
            mul_a   = MUL_A_W'(phi_r);
            acc_add = 1'b1;
          end
          3'd5: begin
            acc_add = 1'b1;
            acc_sh  = 2'd1;
            cof_we  = (t_r == TERM_LAST);
          end
          default: ;
        endcase
      end
      ST_DET: begin
        rd_addr  = {2'b00, k_r[1:0]};
        cof_addr = {k_r[1:0], 2'b00};
        case (ms_r)
          3'd1: begin
            mul_en = 1'b1;
            mul_a  = $signed({{(MUL_A_W-ELEM_W){1'b0}}, cof_rd_r[ELEM_W-1:0]});
          end
          3'd2: begin
            mul_en  = 1'b1;
            mul_a   = $signed({{(MUL_A_W-ELEM_W){1'b0}}, cof_rd_r[2*ELEM_W-1:ELEM_W]});
            acc_add = 1'b1;
          end
          3'd3: begin
            mul_en  = 1'b1;
            mul_a   = MUL_A_W'($signed(cof_rd_r[COF_W-1:2*ELEM_W]));
            acc_add = 1'b1;
            acc_sh  = 2'd1;
          end
          3'd4: begin
            acc_add = 1'b1;
            acc_sh  = 2'd2;
          end
          default: ;
        endcase
      end
      ST_SING: out_load = out_space;
      ST_EMIT: out_load = out_space;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COLLECT;
      thr_r       <= THR_W'(THR_RESET);
      wr_r        <= '0;
      k_r         <= '0;
      ms_r        <= '0;
      t_r         <= '0;
      bit_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_write_en) begin
        thr_r <= cfg_write_data;
      end
      if (q_pop) begin
        wr_r <= wr_r + 1'b1;
      end
      unique case (state_r)
        ST_COLLECT: begin
          k_r  <= '0;
          ms_r <= '0;
          t_r  <= '0;
        end
        ST_COF: begin
          if (ms_r == COF_MS_END) begin
            ms_r <= '0;
            if (t_r == TERM_LAST) begin
              t_r <= '0;
              k_r <= k_r + 1'b1;
            end else begin
              t_r <= t_r + 1'b1;
            end
          end else begin
            ms_r <= ms_r + 1'b1;
          end
        end
        ST_DET: begin
          if (ms_r == DET_MS_END) begin
            ms_r <= '0;
            k_r  <= (k_r[1:0] == 2'd3) ? '0 : k_r + 1'b1;
          end else begin
            ms_r <= ms_r + 1'b1;
          end
        end
        ST_TEST:    k_r <= '0;
        ST_DIV_OVF: bit_r <= 5'd31;
        ST_DIV_RUN: bit_r <= bit_r - 1'b1;
        ST_EMIT: begin
          if (out_space) begin
            k_r <= k_r + 1'b1;
          end
        end
        default: ;
      endcase
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_r] <= q_data.value;
    end
    rd_r <= mem[rd_addr];
    if (cof_we) begin
      cof_mem[k_r] <= acc_sum[COF_W-1:0];
    end
    cof_rd_r <= cof_mem[cof_addr];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_COF && ms_r == 3'd1) begin
      x_r <= rd_r;
    end
    if (state_r == ST_COF && ms_r == 3'd3) begin
      phi_r <= q_r[2*ELEM_W-1:ELEM_W];
    end
    if (mul_en) begin
      q_r <= mul_a * rd_r;
    end
    if (state_r == ST_COLLECT || cof_we) begin
      acc_r <= '0;
    end else if (acc_add) begin
      acc_r <= acc_sum;
    end
    if (state_r == ST_ABS) begin
      det_neg_r <= acc_r[ACC_W-1];
      den_r     <= acc_r[ACC_W-1] ? DEN_W'(-acc_r) : DEN_W'(acc_r);
    end
    if (state_r == ST_DIV_LOAD) begin
      neg_r <= cof_rd_r[COF_W-1] ^ det_neg_r;
      num_r <= NUM_W'(cof_mag) << (2 * FRAC_BITS);
    end
    if (state_r == ST_DIV_OVF) begin
      ovf_r  <= ovf_cmp;
      rem_r  <= DEN_W'(num_r >> ELEM_W);
      lo_r   <= num_r[ELEM_W-1:0];
      quot_r <= '0;
    end
    if (state_r == ST_DIV_RUN) begin
      rem_r  <= ge ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
      quot_r <= {quot_r[ELEM_W-2:0], ge};
    end
    if (out_load) begin
      if (state_r == ST_SING) begin
        out_value_r <= '0;
        out_idx_r   <= '0;
        out_sing_r  <= 1'b1;
        out_last_r  <= 1'b1;
      end else begin
        out_value_r <= neg_r ? ELEM_W'(-sat) : sat;
        out_idx_r   <= k_r;
        out_sing_r  <= 1'b0;
        out_last_r  <= (k_r == {IDX_W{1'b1}});
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_inverse_value = out_value_r;
  assign out_element_index = out_idx_r;
  assign out_singular      = out_sing_r;
  assign out_last_of_run   = out_last_r;

endmodule

@@ rtl/mci_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mci_checker: port checks for the cofactor inverse
// Watches the result channel for hold, ordering and marking rules.
// ----------------------------------------------------------------------------
module mci_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_inverse_value,
  input logic [3:0]  out_element_index,
  input logic        out_singular,
  input logic        out_last_of_run
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_inverse_value)
      && $stable(out_element_index) && $stable(out_last_of_run))
    else $error("Stalled result transaction changed.");

  a_sing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> out_last_of_run && out_element_index == 4'd0
      && out_inverse_value == 32'd0)
    else $error("Singular result is malformed.");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_run && !out_singular |-> out_element_index == 4'd15)
    else $error("Last inverse element has wrong index.");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_run |=> !out_valid
      || (!out_singular && out_element_index == $past(out_element_index) + 4'd1))
    else $error("Inverse elements out of order.");

endmodule

bind matrix4_cofactor_inverse mci_checker u_chk (.*);
